// ===== design/spf_sieve_factorizer_top_macros.svh =====
// ---------------------------------------------------------------------------
// spf sieve factorizer assertion macros
// concurrent assertion wrappers on clk with asynchronous reset arst_n
// ---------------------------------------------------------------------------
`ifndef SPF_SIEVE_FACTORIZER_TOP_MACROS_SVH
`define SPF_SIEVE_FACTORIZER_TOP_MACROS_SVH

`ifndef ASSERT_OFF

`define SPF_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spf assertion failed");

`define SPF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spf assertion failed");

`else

`define SPF_ASSERT_SAME(lbl, ante, cons)

`define SPF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/spf_pkg.sv =====
// ---------------------------------------------------------------------------
// spf_pkg
// shared widths and queue entry type of the sieve factorizer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spf_pkg;

	localparam int NUM_W       = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;

	typedef struct packed {
		logic [NUM_W-1:0] number;
		logic             special;
	} queue_entry_t;

endpackage

`default_nettype wire

// ===== design/spf_if.sv =====
// ---------------------------------------------------------------------------
// spf channel interfaces
// valid/ready channels for input numbers and factor results
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spf_num_if import spf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [NUM_W-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink (input valid, input number, output ready);
endinterface

interface spf_res_if import spf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [NUM_W-1:0] factor;
	logic             number_is_prime;
	logic             no_factor;
	logic             last;

	modport source (output valid, output factor, output number_is_prime,
		output no_factor, output last, input ready);
	modport sink (input valid, input factor, input number_is_prime,
		input no_factor, input last, output ready);
endinterface

`default_nettype wire

// ===== design/spf_sieve_factorizer_top.sv =====
// flow: a number passes the front register and the queue to the table walker, which
// emits its distinct prime factors; a number below two or above the bound gives one
// no_factor result instead. The walker takes a new number only once it is through
// with the last; up to three more wait in the front register and queue
// reset: the table is filled then sieved through the single table write port;
// numbers queue up meanwhile and are held off once full
// ---------------------------------------------------------------------------
// spf_sieve_factorizer_top
// smallest prime factor sieve and distinct prime factorization
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "spf_sieve_factorizer_top_macros.svh"

module spf_sieve_factorizer_top import spf_pkg::*; #(
	parameter int MAX_VALUE = 65535
) (
	input logic       clk,
	input logic       arst_n,
	spf_num_if.sink   items,
	spf_res_if.source results
);

	logic         push_valid;
	logic         push_ready;
	queue_entry_t push_data;
	logic         pop_valid;
	logic         pop_ready;
	queue_entry_t pop_data;

	spf_front #(
		.MAX_VALUE (MAX_VALUE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	spf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	spf_back #(
		.MAX_VALUE (MAX_VALUE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.results   (results)
	);

	`SPF_ASSERT_SAME(a_nofactor_zero, results.valid && results.no_factor, (results.factor == '0) && !results.number_is_prime && results.last)
	`SPF_ASSERT_SAME(a_factor_min, results.valid && !results.no_factor, results.factor >= NUM_W'(2))
	`SPF_ASSERT_NEXT(a_push_hold, push_valid && !push_ready, push_valid && $stable(push_data))
	`SPF_ASSERT_SAME(a_pop_special_emits, pop_ready && pop_data.special, !results.valid || results.ready)

endmodule

`default_nettype wire

// ===== design/spf_queue.sv =====
// ---------------------------------------------------------------------------
// spf_queue
// short fifo between the classifying front and the factoring back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spf_queue import spf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  queue_entry_t push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output queue_entry_t pop_data
);

	queue_entry_t          entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_AW:0]     count_q;
	logic                  push;
	logic                  pop;

	assign push_ready = (count_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_AW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== design/spf_front.sv =====
// ---------------------------------------------------------------------------
// spf_front
// accepts numbers and marks those that have no factor to look up
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spf_front import spf_pkg::*; #(
	parameter int MAX_VALUE = 65535
) (
	input  logic         clk,
	input  logic         arst_n,
	spf_num_if.sink      items,
	output logic         push_valid,
	input  logic         push_ready,
	output queue_entry_t push_data
);

	localparam int               TOP       = (MAX_VALUE < 65535) ? MAX_VALUE : 65535;
	localparam logic [NUM_W-1:0] TOP_N     = NUM_W'(TOP);
	localparam logic [NUM_W-1:0] MIN_PRIME = NUM_W'(2);

	logic         vld_q;
	queue_entry_t ent_q;

	assign items.ready = !vld_q || push_ready;
	assign push_valid  = vld_q;
	assign push_data   = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (items.ready) begin
			vld_q <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			ent_q.number  <= items.number;
			ent_q.special <= (items.number < MIN_PRIME) || (items.number > TOP_N);
		end
	end

endmodule

`default_nettype wire

// ===== design/spf_back.sv =====
// ---------------------------------------------------------------------------
// spf_back
// builds the smallest prime factor table and walks it for each number
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spf_back import spf_pkg::*; #(
	parameter int MAX_VALUE = 65535
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         pop_valid,
	output logic         pop_ready,
	input  queue_entry_t pop_data,
	spf_res_if.source    results
);

	localparam int TOP   = (MAX_VALUE < 65535) ? MAX_VALUE : 65535;
	localparam int AW    = $clog2(TOP + 1);
	localparam int DEPTH = TOP + 1;
	localparam logic [AW-1:0] TOP_A = AW'(TOP);
	localparam logic [AW:0]   TOP_W = (AW+1)'(TOP);
	localparam logic [AW-1:0] ONE_A = AW'(1);

	localparam logic [2:0] ST_FILL   = 3'd0;
	localparam logic [2:0] ST_CHK_RD = 3'd1;
	localparam logic [2:0] ST_CHK_WT = 3'd2;
	localparam logic [2:0] ST_MARK   = 3'd3;
	localparam logic [2:0] ST_NEXT   = 3'd4;
	localparam logic [2:0] ST_IDLE   = 3'd5;
	localparam logic [2:0] ST_LOOK   = 3'd6;
	localparam logic [2:0] ST_FIN    = 3'd7;

	// entry: smallest prime factor in the upper half, cofactor in the lower half
	logic [2*AW-1:0] mem [DEPTH];
	logic [2*AW-1:0] rd_data_q;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [2*AW-1:0] wr_data;
	logic [AW-1:0]   rd_spf;
	logic [AW-1:0]   rd_quo;

	logic [2:0]      state_q;
	logic [2:0]      state_d;
	logic [AW-1:0]   cnt_q;
	logic [AW-1:0]   i_q;
	logic [AW:0]     sq_q;
	logic [AW:0]     m_q;
	logic [AW-1:0]   k_q;
	logic            mk_vld_s1;
	logic [AW-1:0]   m_s1;
	logic [AW-1:0]   k_s1;

	logic [AW-1:0]   n_q;
	logic [AW-1:0]   prev_q;
	logic [AW-1:0]   pend_q;
	logic            pend_vld_q;
	logic            first_q;
	logic            isp_q;

	logic             out_vld_q;
	logic [NUM_W-1:0] out_pf_q;
	logic             out_isp_q;
	logic             out_nf_q;
	logic             out_last_q;

	logic            can_emit;
	logic            is_new;
	logic            need_emit;
	logic            step_go;
	logic            cur_isp;
	logic            emit;
	logic [AW-1:0]   emit_pf;
	logic            emit_isp;
	logic            emit_nf;
	logic            emit_last;

	assign {rd_spf, rd_quo} = rd_data_q;

	assign can_emit  = !out_vld_q || results.ready;
	assign is_new    = (rd_spf != prev_q);
	assign need_emit = is_new && pend_vld_q;
	assign step_go   = !need_emit || can_emit;
	assign cur_isp   = first_q ? (rd_spf == n_q) : isp_q;

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = '0;
		pop_ready = 1'b0;
		emit      = 1'b0;
		emit_pf   = '0;
		emit_isp  = 1'b0;
		emit_nf   = 1'b0;
		emit_last = 1'b0;

		// mark stage: write back only entries still holding their own value
		if (mk_vld_s1 && (rd_spf == m_s1)) begin
			wr_en   = 1'b1;
			wr_addr = m_s1;
			wr_data = {i_q, k_s1};
		end

		unique case (state_q)
			ST_FILL: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q;
				wr_data = {cnt_q, ONE_A};
				if (cnt_q == TOP_A) begin
					state_d = ST_CHK_RD;
				end
			end
			ST_CHK_RD: begin
				if (sq_q > TOP_W) begin
					state_d = ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = i_q;
					state_d = ST_CHK_WT;
				end
			end
			ST_CHK_WT: begin
				if (rd_spf == i_q) begin
					state_d = ST_MARK;
				end else begin
					state_d = ST_NEXT;
				end
			end
			ST_MARK: begin
				if (m_q > TOP_W) begin
					state_d = ST_NEXT;
				end else begin
					rd_en   = 1'b1;
					rd_addr = m_q[AW-1:0];
				end
			end
			ST_NEXT: begin
				state_d = ST_CHK_RD;
			end
			ST_IDLE: begin
				if (pop_valid) begin
					if (pop_data.special) begin
						if (can_emit) begin
							pop_ready = 1'b1;
							emit      = 1'b1;
							emit_nf   = 1'b1;
							emit_last = 1'b1;
						end
					end else begin
						pop_ready = 1'b1;
						rd_en     = 1'b1;
						rd_addr   = pop_data.number[AW-1:0];
						state_d   = ST_LOOK;
					end
				end
			end
			ST_LOOK: begin
				if (step_go) begin
					if (need_emit) begin
						emit     = 1'b1;
						emit_pf  = pend_q;
						emit_isp = cur_isp;
					end
					if (rd_quo == ONE_A) begin
						state_d = ST_FIN;
					end else begin
						rd_en   = 1'b1;
						rd_addr = rd_quo;
					end
				end
			end
			ST_FIN: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_pf   = pend_q;
					emit_isp  = isp_q;
					emit_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_FILL;
			cnt_q      <= '0;
			i_q        <= AW'(2);
			sq_q       <= (AW+1)'(4);
			mk_vld_s1  <= 1'b0;
			pend_vld_q <= 1'b0;
			first_q    <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			mk_vld_s1 <= (state_q == ST_MARK) && (m_q <= TOP_W);
			if (state_q == ST_FILL) begin
				cnt_q <= cnt_q + ONE_A;
			end
			if (state_q == ST_NEXT) begin
				i_q  <= i_q + ONE_A;
				sq_q <= sq_q + {i_q, 1'b1};
			end
			if ((state_q == ST_IDLE) && pop_valid && !pop_data.special) begin
				first_q    <= 1'b1;
				pend_vld_q <= 1'b0;
			end
			if ((state_q == ST_LOOK) && step_go) begin
				first_q <= 1'b0;
				if (is_new) begin
					pend_vld_q <= 1'b1;
				end
			end
			if ((state_q == ST_FIN) && can_emit) begin
				pend_vld_q <= 1'b0;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_CHK_WT) && (rd_spf == i_q)) begin
			m_q <= sq_q;
			k_q <= i_q;
		end else if ((state_q == ST_MARK) && (m_q <= TOP_W)) begin
			m_q <= m_q + {1'b0, i_q};
			k_q <= k_q + ONE_A;
		end
		m_s1 <= m_q[AW-1:0];
		k_s1 <= k_q;
		if ((state_q == ST_IDLE) && pop_valid && !pop_data.special) begin
			n_q    <= pop_data.number[AW-1:0];
			prev_q <= '0;
		end
		if ((state_q == ST_LOOK) && step_go) begin
			isp_q <= cur_isp;
			if (is_new) begin
				pend_q <= rd_spf;
				prev_q <= rd_spf;
			end
		end
		if (emit) begin
			out_pf_q   <= NUM_W'(emit_pf);
			out_isp_q  <= emit_isp;
			out_nf_q   <= emit_nf;
			out_last_q <= emit_last;
		end
	end

	assign results.valid           = out_vld_q;
	assign results.factor          = out_pf_q;
	assign results.number_is_prime = out_isp_q;
	assign results.no_factor       = out_nf_q;
	assign results.last            = out_last_q;

endmodule

`default_nettype wire

// ===== sim/tb_spf_sieve_factorizer_top.sv =====
// ---------------------------------------------------------------------------
// tb_spf_sieve_factorizer_top
// drives numbers into the sieve factorizer while the table is still being
// built and afterwards, predicts the distinct prime factors of each number
// from a smallest-prime-factor table of its own, and checks every result
// transaction field by field with bursty input and a stalling receiver
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_spf_sieve_factorizer_top;
	import spf_pkg::*;

	localparam int SIEVE_BOUND = 65535;
	localparam int MAX_FACTORS = 7;
	localparam int RANDOM_ITEMS = 76;

	typedef struct packed {
		logic [NUM_W-1:0] factor;
		logic             number_is_prime;
		logic             no_factor;
		logic             last;
	} factor_result_t;

	logic clk;
	logic arst_n;

	spf_num_if items_if();
	spf_res_if results_if();

	spf_sieve_factorizer_top #(
		.MAX_VALUE(SIEVE_BOUND)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_if),
		.results(results_if)
	);

	int unsigned    least_prime [0:SIEVE_BOUND];
	factor_result_t factor_q[$];
	int             error_count = 0;
	int             burst_left = 0;
	int unsigned    small_primes[8] = '{2, 3, 5, 7, 11, 13, 17, 19};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic void build_least_prime_table();
		int unsigned i;
		int unsigned m;
		for (i = 0; i <= SIEVE_BOUND; i++)
			least_prime[i] = i;
		for (i = 2; i * i <= SIEVE_BOUND; i++) begin
			if (least_prime[i] == i) begin
				for (m = i * i; m <= SIEVE_BOUND; m += i) begin
					if (least_prime[m] == m)
						least_prime[m] = i;
				end
			end
		end
	endfunction

	function automatic void predict_factors(input logic [NUM_W-1:0] num);
		int unsigned    rest;
		int unsigned    p;
		int unsigned    prev;
		int             count;
		logic           num_prime;
		factor_result_t r;
		factor_result_t found[$];
		if (num < 2 || num > SIEVE_BOUND) begin
			r = '{factor: '0, number_is_prime: 1'b0, no_factor: 1'b1, last: 1'b1};
			factor_q = {factor_q, r};
			return;
		end
		num_prime = (least_prime[num] == num);
		rest = num;
		prev = 0;
		count = 0;
		while (rest > 1 && count < MAX_FACTORS) begin
			p = least_prime[rest];
			if (p < 2)
				break;
			if (p != prev) begin
				r = '{factor: p[NUM_W-1:0], number_is_prime: num_prime,
					no_factor: 1'b0, last: 1'b0};
				found = {found, r};
				count++;
				prev = p;
			end
			rest = rest / p;
		end
		if (count == 0) begin
			r = '{factor: '0, number_is_prime: num_prime, no_factor: 1'b1, last: 1'b1};
			found = {found, r};
		end
		found[found.size() - 1].last = 1'b1;
		foreach (found[k])
			factor_q = {factor_q, found[k]};
	endfunction

	task automatic send_number(input logic [NUM_W-1:0] num);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 8);
			burst_left = $urandom_range(1, 12);
			repeat (gap) begin
				@(negedge clk);
				items_if.valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		items_if.valid <= 1'b1;
		items_if.number <= num;
		@(posedge clk);
		while (!items_if.ready)
			@(posedge clk);
		predict_factors(num);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		items_if.valid <= 1'b0;
		burst_left = 0;
	endtask

	task automatic wait_all_results();
		while (factor_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			error_count++;
		end
	endtask

	// receiver stall pattern
	initial begin
		int mode;
		int phase_left;
		int tick;
		mode = 0;
		phase_left = 0;
		tick = 0;
		results_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (phase_left == 0) begin
				mode = $urandom_range(0, 3);
				phase_left = $urandom_range(10, 80);
			end
			phase_left--;
			tick++;
			case (mode)
			0: begin
				results_if.ready <= 1'b1;
			end
			1: begin
				results_if.ready <= $urandom_range(0, 1);
			end
			2: begin
				results_if.ready <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				results_if.ready <= ((tick % 5) != 0);
			end
			endcase
		end
	end

	always @(posedge clk) begin
		factor_result_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (factor_q.size() == 0) begin
				$error("result transaction with nothing expected: factor %0d",
					results_if.factor);
				error_count++;
			end else begin
				want = factor_q.pop_front();
				compare_field("factor", want.factor, results_if.factor);
				compare_field("number_is_prime", want.number_is_prime,
					results_if.number_is_prime);
				compare_field("no_factor", want.no_factor, results_if.no_factor);
				compare_field("last", want.last, results_if.last);
			end
		end
	end

	// numbers sent while the table is still being sieved
	task automatic test_during_sieve();
		send_number(16'd0);
		send_number(16'd1);
		send_number(16'd2);
		send_number(16'd3);
		send_number(16'd4);
	endtask

	task automatic test_extremes();
		send_number(16'hFFFF);
		send_number(16'hFFFE);
		send_number(16'd65521);
		send_number(16'd32768);
		send_number(16'd59049);
		send_number(16'd30030);
		send_number(16'd60060);
		send_number(16'd46189);
		send_number(16'd65025);
		send_number(16'd64507);
		send_number(16'd49);
		send_number(16'd1);
		send_number(16'd0);
		send_number(16'd5);
		send_number(16'd6);
	endtask

	task automatic test_drain_pause();
		send_number(16'd510);
		send_number(16'd4095);
		stop_sending();
		wait_all_results();
		send_number(16'd9699);
		send_number(16'd2310);
	endtask

	task automatic test_random_numbers();
		int unsigned v;
		int unsigned p;
		int          kind;
		repeat (RANDOM_ITEMS) begin
			kind = $urandom_range(0, 9);
			case (kind)
			0, 1, 2, 3: begin
				v = $urandom_range(0, SIEVE_BOUND);
			end
			4: begin
				v = $urandom_range(0, 15);
			end
			5: begin
				p = small_primes[$urandom_range(0, 7)];
				v = p;
				while (v * p <= SIEVE_BOUND && $urandom_range(0, 3) != 0)
					v = v * p;
			end
			6: begin
				v = 1;
				repeat ($urandom_range(1, 14)) begin
					p = small_primes[$urandom_range(0, 7)];
					if (v * p <= SIEVE_BOUND)
						v = v * p;
				end
			end
			7: begin
				v = SIEVE_BOUND - $urandom_range(0, 255);
			end
			default: begin
				v = $urandom_range(2, SIEVE_BOUND);
				while (v <= SIEVE_BOUND && least_prime[v] != v)
					v++;
				if (v > SIEVE_BOUND)
					v = 65521;
			end
			endcase
			send_number(v[NUM_W-1:0]);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		items_if.valid = 1'b0;
		items_if.number = '0;
		build_least_prime_table();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_during_sieve();
		test_extremes();
		test_drain_pause();
		test_random_numbers();
		stop_sending();
		wait_all_results();
		repeat (40) @(posedge clk);
		if (error_count == 0 && factor_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
